>>> sv/ckd_pkg.sv
// Package for the chord keyboard decoder: button bits, key info type,
// chord id, code ROM and char ROM functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ckd_pkg;

  localparam logic [15:0] BTN_SELECT   = 16'h0001;
  localparam logic [15:0] BTN_START    = 16'h0008;
  localparam logic [15:0] BTN_UP       = 16'h0010;
  localparam logic [15:0] BTN_RIGHT    = 16'h0020;
  localparam logic [15:0] BTN_DOWN     = 16'h0040;
  localparam logic [15:0] BTN_LEFT     = 16'h0080;
  localparam logic [15:0] BTN_LTRIG    = 16'h0100;
  localparam logic [15:0] BTN_RTRIG    = 16'h0200;
  localparam logic [15:0] BTN_TRIANGLE = 16'h1000;
  localparam logic [15:0] BTN_CIRCLE   = 16'h2000;
  localparam logic [15:0] BTN_CROSS    = 16'h4000;
  localparam logic [15:0] BTN_SQUARE   = 16'h8000;

  localparam logic [5:0] ID_TOGGLE_G1 = 6'd63;
  localparam logic [5:0] ID_TOGGLE_G2 = 6'd62;
  localparam logic [5:0] ID_TOGGLE_G3 = 6'd61;

  localparam logic [7:0] MOD_CTRL    = 8'd1;
  localparam logic [7:0] MOD_SHIFT   = 8'd2;
  localparam logic [7:0] MOD_ALT     = 8'd4;
  localparam logic [7:0] MOD_SPECIAL = 8'd8;

  localparam int ROM_LEN = 43;

  // Register indexes on the configuration port
  localparam logic REG_REPEAT_RATE  = 1'b0;
  localparam logic REG_REPEAT_DELAY = 1'b1;

  typedef struct packed {
    logic       found;
    logic [5:0] id;
    logic [1:0] grp;
    logic [7:0] mods;
  } key_info_t;

  localparam logic [7:0] CODE_G0 [ROM_LEN] = '{
    8'd0, 8'd8, 8'd32, 8'd66, 8'd89, 8'd71, 8'd219, 8'd222, 8'd188, 8'd70, 8'd79,
    8'd85, 8'd88, 8'd86, 8'd192, 8'd74, 8'd76, 8'd68, 8'd77, 8'd90, 8'd221, 8'd220,
    8'd81, 8'd80, 8'd83, 8'd84, 8'd67, 8'd186, 8'd87, 8'd75, 8'd82, 8'd69, 8'd65,
    8'd190, 8'd189, 8'd191, 8'd72, 8'd78, 8'd73, 8'd13, 8'd27, 8'd20, 8'd93};
  localparam logic [7:0] CODE_G1 [ROM_LEN] = '{
    8'd0, 8'd8, 8'd32, 8'd112, 8'd113, 8'd119, 8'd219, 8'd186, 8'd188, 8'd114,
    8'd115, 8'd116, 8'd111, 8'd123, 8'd192, 8'd120, 8'd117, 8'd118, 8'd121, 8'd122,
    8'd221, 8'd0, 8'd106, 8'd48, 8'd49, 8'd50, 8'd57, 8'd186, 8'd107, 8'd109,
    8'd51, 8'd52, 8'd53, 8'd190, 8'd189, 8'd0, 8'd56, 8'd54, 8'd55, 8'd13, 8'd27,
    8'd20, 8'd93};
  localparam logic [7:0] CODE_G2 [ROM_LEN] = '{
    8'd0, 8'd40, 8'd13, 8'd37, 8'd36, 8'd45, 8'd0, 8'd0, 8'd0, 8'd35, 8'd38, 8'd33,
    8'd19, 8'd16, 8'd0, 8'd46, 8'd34, 8'd39, 8'd107, 8'd106, 8'd0, 8'd0, 8'd145,
    8'd109, 8'd27, 8'd91, 8'd93, 8'd0, 8'd144, 8'd0, 8'd17, 8'd16, 8'd18, 8'd0,
    8'd0, 8'd0, 8'd9, 8'd92, 8'd20, 8'd13, 8'd27, 8'd20, 8'd8};

  localparam logic [6:0] DIGIT_SHIFTED [10] = '{
    7'd41, 7'd33, 7'd64, 7'd35, 7'd36, 7'd37, 7'd94, 7'd38, 7'd42, 7'd40};

  function automatic logic [7:0] code_rom(input logic [1:0] grp, input logic [5:0] id);
    logic [7:0] v;
    v = 8'd0;
    if (id < 6'(ROM_LEN)) begin
      case (grp)
        2'd0: v = CODE_G0[id];
        2'd1: v = CODE_G1[id];
        2'd2: v = CODE_G2[id];
        default: v = 8'd0;
      endcase
    end
    return v;
  endfunction

  function automatic logic [6:0] char_rom(input logic [7:0] code, input logic [7:0] m);
    logic [6:0] c;
    logic [7:0] dig;
    c = 7'd0;
    dig = code - 8'd48;
    if (m >= 8'd4) begin
      c = 7'd0;
    end else if (code >= 8'd65 && code <= 8'd90) begin
      if (m == 8'd0) c = 7'(code + 8'd32);
      else if (m == MOD_SHIFT) c = code[6:0];
      else if (m == MOD_CTRL && code == 8'd90) c = 7'd26;
    end else if (code >= 8'd48 && code <= 8'd57) begin
      if (m == 8'd0) c = code[6:0];
      else if (m == MOD_SHIFT) c = DIGIT_SHIFTED[dig[3:0]];
    end else if (m == 8'd0) begin
      case (code)
        8'd8, 8'd13, 8'd27, 8'd32: c = code[6:0];
        8'd219: c = 7'd91;
        8'd222: c = 7'd39;
        8'd188: c = 7'd44;
        8'd192: c = 7'd96;
        8'd221: c = 7'd93;
        8'd220: c = 7'd92;
        8'd186: c = 7'd59;
        8'd190: c = 7'd46;
        8'd189: c = 7'd45;
        8'd191: c = 7'd47;
        default: c = 7'd0;
      endcase
    end else if (m == MOD_SHIFT) begin
      case (code)
        8'd219: c = 7'd123;
        8'd222: c = 7'd34;
        8'd188: c = 7'd60;
        8'd192: c = 7'd126;
        8'd221: c = 7'd125;
        8'd220: c = 7'd124;
        8'd186: c = 7'd58;
        8'd190: c = 7'd62;
        8'd189: c = 7'd95;
        8'd191: c = 7'd63;
        default: c = 7'd0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [5:0] chord_id(input logic [15:0] first, input logic [15:0] second);
    logic [5:0] base;
    logic [5:0] tgl;
    logic [5:0] r;
    base = 6'd0;
    tgl = 6'd0;
    r = 6'd0;
    case (first)
      BTN_LTRIG:    r = 6'd41;
      BTN_RTRIG:    r = 6'd42;
      BTN_START:    r = 6'd39;
      BTN_SELECT:   r = 6'd40;
      BTN_DOWN:     r = 6'd1;
      BTN_CROSS:    r = 6'd2;
      BTN_LEFT:     begin base = 6'd3;  tgl = 6'd63; end
      BTN_UP:       begin base = 6'd9;  tgl = 6'd62; end
      BTN_RIGHT:    begin base = 6'd15; tgl = 6'd61; end
      BTN_SQUARE:   begin base = 6'd21; tgl = 6'd60; end
      BTN_TRIANGLE: begin base = 6'd27; tgl = 6'd59; end
      BTN_CIRCLE:   begin base = 6'd33; tgl = 6'd58; end
      default:      r = 6'd0;
    endcase
    if (base != 6'd0) begin
      case (second)
        BTN_DOWN, BTN_CROSS: r = tgl;
        BTN_LEFT:     r = base;
        BTN_UP:       r = base + 6'd1;
        BTN_RIGHT:    r = base + 6'd2;
        BTN_SQUARE:   r = base + 6'd3;
        BTN_TRIANGLE: r = base + 6'd4;
        BTN_CIRCLE:   r = base + 6'd5;
        default:      r = 6'd0;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/ckd_state.sv
// Chord state tracker: holds press history, modifiers, group and repeat
// counters, and decodes each sample into key info. Uses ckd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ckd_state (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [15:0]        buttons,
  input  wire logic [7:0]         repeat_rate,
  input  wire logic [7:0]         repeat_delay,
  output ckd_pkg::key_info_t      info
);

  logic [15:0] prev_r, prev_nxt, pend_r, pend_nxt;
  logic [7:0]  mod_r, mod_nxt, lmod_r, lmod_nxt, thr_r, thr_nxt;
  logic [1:0]  grp_r, grp_nxt, lgrp_r, lgrp_nxt;
  logic [5:0]  lid_r, lid_nxt;
  logic        zs_r, zs_nxt;
  logic [9:0]  rc_r, rc_nxt;

  logic        found;
  logic [5:0]  id;
  logic [3:0]  add;
  logic [8:0]  sum;
  logic [5:0]  tid;
  logic [1:0]  target;

  always_comb begin
    prev_nxt = buttons;
    pend_nxt = pend_r;
    mod_nxt  = mod_r;
    grp_nxt  = grp_r;
    thr_nxt  = thr_r;
    rc_nxt   = rc_r;
    zs_nxt   = zs_r;
    lid_nxt  = lid_r;
    lgrp_nxt = lgrp_r;
    lmod_nxt = lmod_r;
    found    = 1'b0;
    id       = 6'd0;
    add      = 4'd0;
    sum      = 9'd0;
    tid      = 6'd0;
    target   = 2'd0;

    if (buttons == 16'd0) begin
      zs_nxt  = 1'b1;
      thr_nxt = repeat_delay;
      rc_nxt  = 10'd0;
    end
    if (buttons == prev_r) begin
      if (!zs_nxt) begin
        rc_nxt = rc_r + 10'd1;
        if (rc_nxt > 10'({1'b0, thr_r} + {1'b0, repeat_rate})) begin
          thr_nxt = 8'd0;
          rc_nxt  = 10'd0;
          id      = lid_r;
          grp_nxt = lgrp_r;
          mod_nxt = lmod_r;
          found   = 1'b1;
        end
      end
    end else if (buttons != 16'd0) begin
      if (prev_r != 16'd0) begin
        // extra press while holding: accumulate a modifier, saturating
        if ((prev_r & buttons) != buttons) begin
          case (prev_r ^ buttons)
            ckd_pkg::BTN_DOWN, ckd_pkg::BTN_CROSS:     add = ckd_pkg::MOD_SPECIAL[3:0];
            ckd_pkg::BTN_RIGHT, ckd_pkg::BTN_CIRCLE:   add = ckd_pkg::MOD_ALT[3:0];
            ckd_pkg::BTN_SQUARE, ckd_pkg::BTN_LEFT:    add = ckd_pkg::MOD_CTRL[3:0];
            ckd_pkg::BTN_TRIANGLE, ckd_pkg::BTN_UP:    add = ckd_pkg::MOD_SHIFT[3:0];
            default: add = 4'd0;
          endcase
        end
        sum = {1'b0, mod_r} + {5'd0, add};
        mod_nxt = sum[8] ? 8'hFF : sum[7:0];
        tid = ckd_pkg::chord_id(prev_r, buttons & ~prev_r);
        case (tid)
          ckd_pkg::ID_TOGGLE_G1: target = 2'd1;
          ckd_pkg::ID_TOGGLE_G2: target = 2'd2;
          ckd_pkg::ID_TOGGLE_G3: target = 2'd3;
          default: target = 2'd0;
        endcase
        if (mod_nxt != 8'd0 && target != 2'd0) begin
          grp_nxt  = (grp_r == target) ? 2'd0 : target;
          mod_nxt  = 8'd0;
          pend_nxt = 16'd0;
        end
      end else if (pend_r != 16'd0) begin
        id    = ckd_pkg::chord_id(pend_r, buttons);
        found = 1'b1;
      end else begin
        id = ckd_pkg::chord_id(buttons, 16'd0);
        if (id != 6'd0) found = 1'b1;
        else pend_nxt = buttons;
      end
    end else begin
      thr_nxt = repeat_delay;
    end

    info.found = found;
    info.id    = id;
    info.grp   = grp_nxt;
    info.mods  = mod_nxt;

    if (found) begin
      zs_nxt   = 1'b0;
      lid_nxt  = id;
      lgrp_nxt = grp_nxt;
      lmod_nxt = mod_nxt;
      pend_nxt = 16'd0;
      mod_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 16'd0;
      pend_r <= 16'd0;
      mod_r  <= 8'd0;
      grp_r  <= 2'd0;
      lid_r  <= 6'd0;
      lgrp_r <= 2'd0;
      lmod_r <= 8'd0;
      zs_r   <= 1'b0;
      thr_r  <= 8'd16;
      rc_r   <= 10'd0;
    end else if (step) begin
      prev_r <= prev_nxt;
      pend_r <= pend_nxt;
      mod_r  <= mod_nxt;
      grp_r  <= grp_nxt;
      lid_r  <= lid_nxt;
      lgrp_r <= lgrp_nxt;
      lmod_r <= lmod_nxt;
      zs_r   <= zs_nxt;
      thr_r  <= thr_nxt;
      rc_r   <= rc_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/chord_keyboard_decoder.sv
// Top level of the chord keyboard decoder: stream ports, APB registers,
// code ROM read stage and output register. Uses ckd_pkg and ckd_state.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction carries one 16-bit pad button mask and yields
// exactly one result transaction. The block accepts one sample per clock
// unless a stalled output finds the ROM stage full. The chord state is
// updated and the code ROM is read (registered) first; the character is
// then derived and held in the output register. A stalled output holds
// the pipeline; while the ROM stage is free, a new sample is still taken.
// A repeated key is rebuilt from the stored key id, group and modifier,
// which name the same code ROM entry as the original press. Registers:
// repeat_rate at 0x0 (reset 2) and repeat_delay at 0x4 (reset 16); a new
// delay takes effect at the next all-released sample. Write the registers
// only while the block is idle.
module chord_keyboard_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // buttons[15:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // key_id[5:0], key_code[13:6], key_char[20:14], key_group[22:21],
  // modifiers[30:23], zero [31]
  output      logic [31:0] out_tdata,
  output      logic        out_tuser,  // key_found
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  logic [7:0] rate_r, delay_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= 8'd2;
      delay_r <= 8'd16;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        ckd_pkg::REG_REPEAT_RATE:  rate_r  <= cfg_pwdata[7:0];
        ckd_pkg::REG_REPEAT_DELAY: delay_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      ckd_pkg::REG_REPEAT_RATE:  cfg_prdata = {24'd0, rate_r};
      ckd_pkg::REG_REPEAT_DELAY: cfg_prdata = {24'd0, delay_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline control: advance the output register when it is empty or taken
  logic adv, in_acc, rom_v_r;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv || !rom_v_r;
  assign in_acc    = in_tvalid && in_tready;

  ckd_pkg::key_info_t info, info_r;

  ckd_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_acc),
    .buttons      (in_tdata),
    .repeat_rate  (rate_r),
    .repeat_delay (delay_r),
    .info         (info)
  );

  // Code ROM: registered read addressed by group and chord id
  logic [7:0] code_r;
  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r <= ckd_pkg::code_rom(info.grp, info.id);
      info_r <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_v_r    <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (in_acc) rom_v_r <= 1'b1;
      else if (adv) rom_v_r <= 1'b0;
      if (adv) out_tvalid <= rom_v_r;
    end
  end

  // Output register: the character follows from the code and the modifier
  always_ff @(posedge clk) begin
    if (adv && rom_v_r) begin
      out_tuser <= info_r.found;
      out_tdata <= {1'b0, info_r.mods, info_r.grp,
                    ckd_pkg::char_rom(code_r, info_r.mods), code_r, info_r.id};
    end
  end

endmodule
`default_nettype wire

>>> sv/ckd_checker.sv
// Port-level checker for chord_keyboard_decoder, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module ckd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped under stall");

  a_nokey: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[20:0] == 21'd0)
    else $error("non-key result carries key data");

  a_grp3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22:21] == 2'd3 && out_tuser |-> out_tdata[13:6] == 8'd0)
    else $error("group 3 key has nonzero code");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind chord_keyboard_decoder ckd_checker u_ckd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
